FILE: src/sfcs_pkg.sv
// Shared types and constants for the state feedback control step block.
package sfcs_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned AccW = 52;
	localparam int unsigned ProdW = 64;
	localparam logic signed [DataW-1:0] QOne = 32'sh0001_0000;

	typedef enum logic [2:0] {
		CMD_STEP = 3'd0,
		CMD_WR_K = 3'd1,
		CMD_WR_N = 3'd2,
		CMD_WR_A = 3'd3,
		CMD_WR_B = 3'd4,
		CMD_WR_X = 3'd5,
		CMD_CLR_X = 3'd6
	} cmd_t;

	localparam logic CfgNumStates = 1'b0;
	localparam logic CfgNumControls = 1'b1;

	typedef struct packed {
		logic [2:0] cmd;
		logic [1:0] row;
		logic [1:0] col;
		logic signed [31:0] coef_value;
		logic signed [31:0] ref_0;
		logic signed [31:0] ref_1;
		logic use_external;
		logic signed [31:0] ext_x0;
		logic signed [31:0] ext_x1;
		logic signed [31:0] ext_x2;
		logic signed [31:0] ext_x3;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] u_0;
		logic signed [31:0] u_1;
		logic signed [31:0] x_0;
		logic signed [31:0] x_1;
		logic signed [31:0] x_2;
		logic signed [31:0] x_3;
	} out_item_t;

	// MAC control: clear accumulator, subtract term
	typedef struct packed {
		logic en;
		logic clr;
		logic neg;
	} mac_ctl_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] hi;
		logic signed [AccW-1:0] lo;
		begin
			hi = AccW'(32'sh7fff_ffff);
			lo = -AccW'(64'sh8000_0000);
			if (v > hi) sat32 = 32'sh7fff_ffff;
			else if (v < lo) sat32 = 32'sh8000_0000;
			else sat32 = v[DataW-1:0];
		end
	endfunction

endpackage

FILE: src/sfcs_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface sfcs_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: src/sfcs_mac.sv
// Shared Q16.16 multiply-accumulate unit with combinational product and registered accumulator.
module sfcs_mac (
	input logic clk,
	input sfcs_pkg::mac_ctl_t ctl,
	input logic signed [sfcs_pkg::DataW-1:0] a,
	input logic signed [sfcs_pkg::DataW-1:0] b,
	output logic signed [sfcs_pkg::AccW-1:0] acc
);
	logic signed [sfcs_pkg::ProdW-1:0] prod;
	logic signed [sfcs_pkg::AccW-1:0] term;
	logic signed [sfcs_pkg::AccW-1:0] acc_q;

	assign prod = (sfcs_pkg::ProdW'(a) * sfcs_pkg::ProdW'(b)) + sfcs_pkg::ProdW'(32768);
	assign term = sfcs_pkg::AccW'(prod >>> 16);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.clr) acc_q <= ctl.neg ? -term : term;
			else acc_q <= ctl.neg ? acc_q - term : acc_q + term;
		end
	end
	assign acc = acc_q;
endmodule

FILE: src/state_feedback_control_step.sv
// Top level of the state feedback control step block.
// Write/clear items update registers directly; a step computes u = N*r - K*x, then
// x' = A*x + B*u unless external state is used, on one shared MAC;
// one item at a time.
// Result sits in an output register; a new item is taken once it drains.
// arst_n resets control (n=2, m=1) and clears matrices (N to identity), state and registers.
module state_feedback_control_step #(
	parameter int unsigned MAX_STATES = 4,
	parameter int unsigned MAX_CONTROLS = 2
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [2:0] cfg_wdata,
	sfcs_stream_if.sink in_ch,
	sfcs_stream_if.source out_ch
);
	localparam int unsigned SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int unsigned CW = (MAX_CONTROLS > 1) ? $clog2(MAX_CONTROLS) : 1;
	localparam int unsigned JW = $clog2(MAX_STATES + MAX_CONTROLS + 1);
	localparam int unsigned RW = $clog2(MAX_STATES + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_U = 4'b0010,
		ST_X = 4'b0100,
		ST_OUT = 4'b1000
	} state_t;

	state_t state_q;
	logic [2:0] num_states_q;
	logic [1:0] num_controls_q;
	logic signed [31:0] k_q [MAX_CONTROLS][MAX_STATES];
	logic signed [31:0] n_q [MAX_CONTROLS][MAX_CONTROLS];
	logic signed [31:0] a_q [MAX_STATES][MAX_STATES];
	logic signed [31:0] b_q [MAX_STATES][MAX_CONTROLS];
	logic signed [31:0] x_q [MAX_STATES];
	logic signed [31:0] xn_q [MAX_STATES];
	logic signed [31:0] xv_q [MAX_STATES];
	logic signed [31:0] r_q [MAX_CONTROLS];
	logic signed [31:0] u_q [MAX_CONTROLS];
	logic ext_q;
	logic [RW-1:0] i_q;
	logic [JW-1:0] j_q;
	logic pend_q;
	logic [RW-1:0] pi_q;
	logic out_valid_q;
	sfcs_pkg::out_item_t out_q;

	logic [RW-1:0] n_eff;
	logic [CW:0] m_eff;
	sfcs_pkg::mac_ctl_t ctl;
	logic signed [31:0] op_a, op_b;
	logic signed [sfcs_pkg::AccW-1:0] acc;
	logic [JW-1:0] jlen;
	logic [RW-1:0] ilen;
	logic last_j;
	sfcs_pkg::in_item_t it;

	assign it = in_ch.payload;
	assign n_eff = (32'(num_states_q) > MAX_STATES) ? RW'(MAX_STATES) : RW'(num_states_q);
	assign m_eff = (32'(num_controls_q) > MAX_CONTROLS) ? (CW+1)'(MAX_CONTROLS)
		: (CW+1)'(num_controls_q);
	assign jlen = (state_q == ST_U) ? JW'(n_eff) + JW'(m_eff) : JW'(n_eff) + JW'(m_eff);
	assign ilen = (state_q == ST_U) ? RW'(m_eff) : n_eff;
	assign last_j = (j_q == jlen - JW'(1));
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q && !pend_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	always_comb begin
		op_a = '0;
		op_b = '0;
		ctl.neg = 1'b0;
		if (state_q == ST_U) begin
			if (j_q < JW'(n_eff)) begin
				op_a = k_q[i_q[CW-1:0]][j_q[SW-1:0]];
				op_b = xv_q[j_q[SW-1:0]];
				ctl.neg = 1'b1;
			end else begin
				op_a = n_q[i_q[CW-1:0]][CW'(j_q - JW'(n_eff))];
				op_b = r_q[CW'(j_q - JW'(n_eff))];
			end
		end else begin
			if (j_q < JW'(n_eff)) begin
				op_a = a_q[i_q[SW-1:0]][j_q[SW-1:0]];
				op_b = x_q[j_q[SW-1:0]];
			end else begin
				op_a = b_q[i_q[SW-1:0]][CW'(j_q - JW'(n_eff))];
				op_b = u_q[CW'(j_q - JW'(n_eff))];
			end
		end
		ctl.en = (state_q == ST_U || state_q == ST_X) && jlen != '0 && i_q < ilen;
		ctl.clr = (j_q == '0);
	end

	sfcs_mac u_mac (.clk(clk), .ctl(ctl), .a(op_a), .b(op_b), .acc(acc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_states_q <= 3'd2;
			num_controls_q <= 2'd1;
			out_valid_q <= 1'b0;
			out_q <= '0;
			pend_q <= 1'b0;
			pi_q <= '0;
			i_q <= '0;
			j_q <= '0;
			ext_q <= 1'b0;
			for (int r = 0; r < MAX_CONTROLS; r++) begin
				for (int c = 0; c < MAX_STATES; c++) k_q[r][c] <= '0;
				for (int c = 0; c < MAX_CONTROLS; c++)
					n_q[r][c] <= (r == c) ? sfcs_pkg::QOne : '0;
				r_q[r] <= '0;
				u_q[r] <= '0;
			end
			for (int r = 0; r < MAX_STATES; r++) begin
				for (int c = 0; c < MAX_STATES; c++) a_q[r][c] <= '0;
				for (int c = 0; c < MAX_CONTROLS; c++) b_q[r][c] <= '0;
				x_q[r] <= '0;
				xn_q[r] <= '0;
				xv_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == sfcs_pkg::CfgNumStates) num_states_q <= cfg_wdata;
				else num_controls_q <= cfg_wdata[1:0];
			end
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			// store finished sum in the cycle after its last term
			pend_q <= 1'b0;
			if (pend_q) begin
				if (state_q == ST_U || (state_q == ST_X && i_q == '0 && !ext_q && jlen != '0
					&& 1'b0)) u_q[pi_q[CW-1:0]] <= sfcs_pkg::sat32(acc);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						case (it.cmd)
							sfcs_pkg::CMD_STEP: begin
								r_q[0] <= it.ref_0;
								if (MAX_CONTROLS > 1) r_q[CW'(MAX_CONTROLS > 1)] <= it.ref_1;
								for (int c = 2; c < MAX_CONTROLS; c++) r_q[c] <= '0;
								for (int c = 0; c < MAX_STATES; c++) begin
									if (!it.use_external) xv_q[c] <= x_q[c];
									else if (c == 0) xv_q[c] <= it.ext_x0;
									else if (c == 1) xv_q[c] <= it.ext_x1;
									else if (c == 2) xv_q[c] <= it.ext_x2;
									else if (c == 3) xv_q[c] <= it.ext_x3;
									else xv_q[c] <= '0;
								end
								for (int c = 0; c < MAX_CONTROLS; c++) u_q[c] <= '0;
								ext_q <= it.use_external;
								i_q <= '0;
								j_q <= '0;
								state_q <= ST_U;
							end
							sfcs_pkg::CMD_WR_K: if (32'(it.row) < MAX_CONTROLS && 32'(it.col) < MAX_STATES)
								k_q[it.row[CW-1:0]][it.col[SW-1:0]] <= it.coef_value;
							sfcs_pkg::CMD_WR_N: if (32'(it.row) < MAX_CONTROLS && 32'(it.col) < MAX_CONTROLS)
								n_q[it.row[CW-1:0]][it.col[CW-1:0]] <= it.coef_value;
							sfcs_pkg::CMD_WR_A: if (32'(it.row) < MAX_STATES && 32'(it.col) < MAX_STATES)
								a_q[it.row[SW-1:0]][it.col[SW-1:0]] <= it.coef_value;
							sfcs_pkg::CMD_WR_B: if (32'(it.row) < MAX_STATES && 32'(it.col) < MAX_CONTROLS)
								b_q[it.row[SW-1:0]][it.col[CW-1:0]] <= it.coef_value;
							sfcs_pkg::CMD_WR_X: if (32'(it.row) < MAX_STATES)
								x_q[it.row[SW-1:0]] <= it.coef_value;
							sfcs_pkg::CMD_CLR_X: for (int c = 0; c < MAX_STATES; c++) x_q[c] <= '0;
							default: ;
						endcase
					end
				end
				ST_U, ST_X: begin
					if (pend_q && state_q == ST_X) xn_q[pi_q[SW-1:0]] <= sfcs_pkg::sat32(acc);
					if (!ctl.en) begin
						// wait out the last stored sum, then advance
						if (!pend_q) begin
							if (state_q == ST_U && !ext_q) begin
								state_q <= ST_X;
								for (int c = 0; c < MAX_STATES; c++) xn_q[c] <= x_q[c];
							end else begin
								state_q <= ST_OUT;
							end
							i_q <= '0;
							j_q <= '0;
						end
					end else if (last_j) begin
						pend_q <= 1'b1;
						pi_q <= i_q;
						j_q <= '0;
						i_q <= i_q + RW'(1);
					end else begin
						j_q <= j_q + JW'(1);
					end
				end
				ST_OUT: begin
					if (!ext_q) for (int c = 0; c < MAX_STATES; c++) x_q[c] <= xn_q[c];
					out_q.u_0 <= u_q[0];
					out_q.u_1 <= (MAX_CONTROLS > 1) ? u_q[CW'(MAX_CONTROLS > 1)] : '0;
					out_q.x_0 <= ext_q ? x_q[0] : xn_q[0];
					out_q.x_1 <= (MAX_STATES > 1) ? (ext_q ? x_q[SW'(1)] : xn_q[SW'(1)]) : '0;
					out_q.x_2 <= (MAX_STATES > 2) ? (ext_q ? x_q[SW'(2)] : xn_q[SW'(2)]) : '0;
					out_q.x_3 <= (MAX_STATES > 3) ? (ext_q ? x_q[SW'(3)] : xn_q[SW'(3)]) : '0;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
